@@ src/ate_pkg.sv @@
// alarm table engine package: opcodes, result codes, transaction and packet types
// no dependencies; used by every other file of the block
package ate_pkg;

    localparam int NUM_SLOTS_DEF = 8;

    localparam logic [16:0] SEC_PER_DAY = 17'd86400;

    localparam logic [2:0] OP_DELETE  = 3'd0;
    localparam logic [2:0] OP_SET     = 3'd1;
    localparam logic [2:0] OP_CYCLE   = 3'd2;
    localparam logic [2:0] OP_AT_DAY  = 3'd3;
    localparam logic [2:0] OP_RESET   = 3'd4;
    localparam logic [2:0] OP_CLEANUP = 3'd5;
    localparam logic [2:0] OP_TICK    = 3'd6;

    localparam logic [1:0] KIND_RSP   = 2'd0;
    localparam logic [1:0] KIND_FIRED = 2'd1;
    localparam logic [1:0] KIND_IDLE  = 2'd2;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_PARAM = 2'd1;
    localparam logic [1:0] ERR_PROC  = 2'd2;
    localparam logic [1:0] ERR_OPC   = 2'd3;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [15:0] caller_pid;
        logic [31:0] alarm_handle;
        logic [15:0] signal_code;
        logic [31:0] interval_ticks;
        logic [31:0] target_day;
        logic [16:0] target_second;
        logic [31:0] now_day;
        logic [16:0] now_second;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        ok;
        logic [31:0] result_id;
        logic [1:0]  error_code;
        logic [15:0] target_pid;
        logic [15:0] fired_signal;
        logic [3:0]  fired_count;
        logic        last;
    } out_item_t;

    // command packet travelling down the row of slot cells
    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] pid;
        logic [31:0] aid;
        logic [15:0] sig;
        logic [31:0] ivl;
        logic [31:0] tday;
        logic [16:0] tsec;
        logic [31:0] nday;
        logic [16:0] nsec;
        logic [31:0] rid;
        logic [1:0]  err;
        logic        done;
        logic        pend;
        logic [15:0] ppid;
        logic [15:0] psig;
        logic [3:0]  cnt;
    } pkt_t;

endpackage

@@ src/ate_in_if.sv @@
// input channel of the alarm table engine: valid/ready with one request item
// depends on ate_pkg
interface ate_in_if;
    logic               valid;
    logic               ready;
    ate_pkg::in_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ src/ate_out_if.sv @@
// output channel of the alarm table engine: valid/ready with one result item
// depends on ate_pkg
interface ate_out_if;
    logic               valid;
    logic               ready;
    ate_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ src/ate_cell.sv @@
// one alarm slot: holds the slot state and applies the passing command packet
// depends on ate_pkg
module ate_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               stall,
    input  logic               vin,
    input  ate_pkg::pkt_t      pin,
    output logic               vout,
    output ate_pkg::pkt_t      pout,
    output logic               emit,
    output ate_pkg::out_item_t emit_res
);

    logic          vld_reg;
    ate_pkg::pkt_t pkt_reg, pkt_next;
    logic [31:0]   ident_reg, ident_next;
    logic [15:0]   owner_reg, owner_next;
    logic [15:0]   sig_reg, sig_next;
    logic [31:0]   rem_reg, rem_next;
    logic [31:0]   day_reg, day_next;
    logic [16:0]   sec_reg, sec_next;
    logic [31:0]   per_reg, per_next;

    logic active, used, own, due;

    assign active = vin && (pin.err == ate_pkg::ERR_NONE);
    assign used   = (ident_reg != 32'd0);
    assign own    = used && (owner_reg == pin.pid);
    assign due    = (rem_reg == 32'd0)
                    ? ((pin.nday > day_reg) || ((pin.nday == day_reg) && (pin.nsec >= sec_reg)))
                    : (rem_reg == 32'd1);

    // apply the packet to this slot
    always_comb
    begin
        pkt_next   = pin;
        ident_next = ident_reg;
        owner_next = owner_reg;
        sig_next   = sig_reg;
        rem_next   = rem_reg;
        day_next   = day_reg;
        sec_next   = sec_reg;
        per_next   = per_reg;
        emit       = 1'b0;
        emit_res   = '0;
        if (active)
        begin
            case (pin.op)
                ate_pkg::OP_DELETE, ate_pkg::OP_CLEANUP:
                begin
                    if (own && (pin.pid != 16'd0) && ((pin.op == ate_pkg::OP_CLEANUP) ||
                        (pin.aid == 32'd0) || (ident_reg == pin.aid)))
                    begin
                        ident_next = '0;
                        owner_next = '0;
                        sig_next   = '0;
                        rem_next   = '0;
                        day_next   = '0;
                        sec_next   = '0;
                        per_next   = '0;
                    end
                end
                ate_pkg::OP_SET, ate_pkg::OP_CYCLE, ate_pkg::OP_AT_DAY:
                begin
                    if (!used && !pin.done)
                    begin
                        pkt_next.done = 1'b1;
                        ident_next = pin.rid;
                        owner_next = pin.pid;
                        sig_next   = pin.sig;
                        if (pin.op == ate_pkg::OP_AT_DAY)
                        begin
                            rem_next = '0;
                            per_next = '0;
                            day_next = pin.tday;
                            sec_next = pin.tsec;
                        end
                        else
                        begin
                            rem_next = pin.ivl;
                            per_next = (pin.op == ate_pkg::OP_CYCLE) ? pin.ivl : 32'd0;
                            day_next = '0;
                            sec_next = '0;
                        end
                    end
                end
                ate_pkg::OP_RESET:
                begin
                    if (own && (ident_reg == pin.aid) && !pin.done)
                    begin
                        pkt_next.done = 1'b1;
                        sig_next = pin.sig;
                        rem_next = pin.ivl;
                        day_next = '0;
                        sec_next = '0;
                    end
                end
                ate_pkg::OP_TICK:
                begin
                    if (used && due)
                    begin
                        // the previous firing is now known not to be the last one
                        if (pin.pend)
                        begin
                            emit                  = 1'b1;
                            emit_res.kind         = ate_pkg::KIND_FIRED;
                            emit_res.ok           = 1'b1;
                            emit_res.target_pid   = pin.ppid;
                            emit_res.fired_signal = pin.psig;
                            emit_res.fired_count  = pin.cnt;
                        end
                        pkt_next.pend = 1'b1;
                        pkt_next.ppid = owner_reg;
                        pkt_next.psig = sig_reg;
                        pkt_next.cnt  = pin.cnt + 4'd1;
                        if (per_reg != 32'd0)
                        begin
                            rem_next = per_reg;
                        end
                        else
                        begin
                            ident_next = '0;
                            owner_next = '0;
                            sig_next   = '0;
                            rem_next   = '0;
                            day_next   = '0;
                            sec_next   = '0;
                            per_next   = '0;
                        end
                    end
                    else if (used && (rem_reg > 32'd1))
                    begin
                        rem_next = rem_reg - 32'd1;
                    end
                end
                default:
                begin
                    pkt_next = pin;
                end
            endcase
        end
    end

    // slot state and packet hand-off
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= 1'b0;
            ident_reg <= '0;
            owner_reg <= '0;
            sig_reg   <= '0;
            rem_reg   <= '0;
            day_reg   <= '0;
            sec_reg   <= '0;
            per_reg   <= '0;
        end
        else if (!stall)
        begin
            vld_reg   <= vin;
            ident_reg <= ident_next;
            owner_reg <= owner_next;
            sig_reg   <= sig_next;
            rem_reg   <= rem_next;
            day_reg   <= day_next;
            sec_reg   <= sec_next;
            per_reg   <= per_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            pkt_reg <= pkt_next;
        end
    end

    assign vout = vld_reg;
    assign pout = pkt_reg;

endmodule

@@ src/alarm_table_engine.sv @@
// alarm table engine top level: request check, row of slot cells, result stage
// a request passes the head register, every slot cell register and the output register to its
// final result, and output stalls hold it; one request at a time, the next is taken once the
// final result is registered, as set by the packet walking the slot row
// reset: asynchronous, clears every slot, the id counter and all valid flags
// depends on ate_pkg, ate_in_if, ate_out_if and ate_cell
module alarm_table_engine #(
    parameter int NUM_SLOTS = ate_pkg::NUM_SLOTS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    ate_in_if.sink     req,
    ate_out_if.source  rsp
);

    logic                  busy_reg;
    logic [31:0]           id_reg;
    logic                  out_vld_reg;
    ate_pkg::out_item_t    out_res_reg;
    logic                  hd_vld_reg;
    ate_pkg::pkt_t         hd_pkt_reg, hd_pkt_next;

    logic                  vld [NUM_SLOTS+1];
    ate_pkg::pkt_t         pkt [NUM_SLOTS+1];
    logic [NUM_SLOTS-1:0]  emit_v;
    ate_pkg::out_item_t    emit_r [NUM_SLOTS];
    ate_pkg::out_item_t    emit_sel, tail_res;

    logic accept, out_free, stall, tail_go;
    logic [31:0] nid;

    assign req.ready = !busy_reg;
    assign accept    = req.valid && !busy_reg;
    assign out_free  = !out_vld_reg || rsp.ready;
    assign stall     = ((|emit_v) || vld[NUM_SLOTS]) && !out_free;
    assign tail_go   = vld[NUM_SLOTS] && out_free;
    assign nid       = ((id_reg + 32'd1) == 32'd0) ? 32'd1 : (id_reg + 32'd1);

    // request check and packet build
    always_comb
    begin
        hd_pkt_next      = '0;
        hd_pkt_next.op   = req.data.opcode;
        hd_pkt_next.pid  = req.data.caller_pid;
        hd_pkt_next.aid  = req.data.alarm_handle;
        hd_pkt_next.sig  = req.data.signal_code;
        hd_pkt_next.ivl  = req.data.interval_ticks;
        hd_pkt_next.tday = req.data.target_day;
        hd_pkt_next.tsec = req.data.target_second;
        hd_pkt_next.nday = req.data.now_day;
        hd_pkt_next.nsec = req.data.now_second;
        case (req.data.opcode)
            ate_pkg::OP_DELETE:
            begin
                if (req.data.caller_pid == 16'd0)
                    hd_pkt_next.err = ate_pkg::ERR_PROC;
            end
            ate_pkg::OP_SET, ate_pkg::OP_CYCLE:
            begin
                hd_pkt_next.rid = nid;
                if (req.data.interval_ticks == 32'd0)
                    hd_pkt_next.err = ate_pkg::ERR_PARAM;
                else if (req.data.caller_pid == 16'd0)
                    hd_pkt_next.err = ate_pkg::ERR_PROC;
            end
            ate_pkg::OP_AT_DAY:
            begin
                hd_pkt_next.rid = nid;
                if ((req.data.target_day == 32'd0) ||
                    (req.data.target_second >= ate_pkg::SEC_PER_DAY))
                    hd_pkt_next.err = ate_pkg::ERR_PARAM;
                else if (req.data.caller_pid == 16'd0)
                    hd_pkt_next.err = ate_pkg::ERR_PROC;
            end
            ate_pkg::OP_RESET:
            begin
                hd_pkt_next.rid = req.data.alarm_handle;
                if (req.data.interval_ticks == 32'd0)
                    hd_pkt_next.err = ate_pkg::ERR_PARAM;
                else if (req.data.caller_pid == 16'd0)
                    hd_pkt_next.err = ate_pkg::ERR_PROC;
            end
            ate_pkg::OP_CLEANUP, ate_pkg::OP_TICK:
            begin
                hd_pkt_next.err = ate_pkg::ERR_NONE;
            end
            default:
            begin
                hd_pkt_next.err = ate_pkg::ERR_OPC;
            end
        endcase
    end

    // head stage of the row
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hd_vld_reg <= 1'b0;
        end
        else if (accept)
        begin
            hd_vld_reg <= 1'b1;
        end
        else if (!stall)
        begin
            hd_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hd_pkt_reg <= hd_pkt_next;
        end
    end

    assign vld[0] = hd_vld_reg;
    assign pkt[0] = hd_pkt_reg;

    // row of slot cells
    for (genvar i = 0; i < NUM_SLOTS; i++)
    begin : g_cell
        ate_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .stall    (stall),
            .vin      (vld[i]),
            .pin      (pkt[i]),
            .vout     (vld[i+1]),
            .pout     (pkt[i+1]),
            .emit     (emit_v[i]),
            .emit_res (emit_r[i])
        );
    end

    // at most one cell holds the packet, so the emitted results merge by or
    always_comb
    begin
        emit_sel = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            emit_sel = emit_sel | emit_r[i];
        end
    end

    // final result of the request
    always_comb
    begin
        tail_res      = '0;
        tail_res.last = 1'b1;
        if (pkt[NUM_SLOTS].op == ate_pkg::OP_TICK)
        begin
            tail_res.ok = 1'b1;
            if (pkt[NUM_SLOTS].pend)
            begin
                tail_res.kind         = ate_pkg::KIND_FIRED;
                tail_res.target_pid   = pkt[NUM_SLOTS].ppid;
                tail_res.fired_signal = pkt[NUM_SLOTS].psig;
                tail_res.fired_count  = pkt[NUM_SLOTS].cnt;
            end
            else
            begin
                tail_res.kind = ate_pkg::KIND_IDLE;
            end
        end
        else
        begin
            tail_res.kind       = ate_pkg::KIND_RSP;
            tail_res.error_code = pkt[NUM_SLOTS].err;
            if ((pkt[NUM_SLOTS].err == ate_pkg::ERR_NONE) && !pkt[NUM_SLOTS].done &&
                ((pkt[NUM_SLOTS].op == ate_pkg::OP_SET) ||
                 (pkt[NUM_SLOTS].op == ate_pkg::OP_CYCLE) ||
                 (pkt[NUM_SLOTS].op == ate_pkg::OP_AT_DAY) ||
                 (pkt[NUM_SLOTS].op == ate_pkg::OP_RESET)))
            begin
                tail_res.error_code = ate_pkg::ERR_PARAM;
            end
            tail_res.ok        = (tail_res.error_code == ate_pkg::ERR_NONE);
            tail_res.result_id = tail_res.ok ? pkt[NUM_SLOTS].rid : 32'd0;
        end
    end

    // busy flag, id counter and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            id_reg      <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                busy_reg <= 1'b1;
            else if (tail_go)
                busy_reg <= 1'b0;
            if (tail_go && pkt[NUM_SLOTS].done && (pkt[NUM_SLOTS].err == ate_pkg::ERR_NONE) &&
                ((pkt[NUM_SLOTS].op == ate_pkg::OP_SET) ||
                 (pkt[NUM_SLOTS].op == ate_pkg::OP_CYCLE) ||
                 (pkt[NUM_SLOTS].op == ate_pkg::OP_AT_DAY)))
                id_reg <= pkt[NUM_SLOTS].rid;
            if (tail_go || ((|emit_v) && out_free))
                out_vld_reg <= 1'b1;
            else if (rsp.ready)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tail_go)
            out_res_reg <= tail_res;
        else if ((|emit_v) && out_free)
            out_res_reg <= emit_sel;
    end

    assign rsp.valid = out_vld_reg;
    assign rsp.data  = out_res_reg;

endmodule

@@ src/ate_checker.sv @@
// port-level checks of the alarm table engine, bound to the top level
// depends on ate_pkg and alarm_table_engine
module ate_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic               in_valid,
    input logic               in_ready,
    input ate_pkg::out_item_t out_data
);

    // a waiting result transaction is not withdrawn
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // one request at a time
    a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while busy");

    // an empty tick is a single final result with no count
    a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.kind == ate_pkg::KIND_IDLE) |->
        out_data.last && out_data.ok && (out_data.fired_count == 4'd0))
        else $error("bad empty tick result");

    // fired results carry a count, command responses are final
    a_fired: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.kind == ate_pkg::KIND_FIRED) |->
        out_data.ok && (out_data.fired_count != 4'd0))
        else $error("bad fired result");

    a_rsp_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.kind == ate_pkg::KIND_RSP) |-> out_data.last)
        else $error("command response not final");

endmodule

bind alarm_table_engine ate_checker u_ate_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_data  (rsp.data)
);
